// File: sv/sokl_pkg.sv
`default_nettype none

package sokl_pkg;

  // List geometry
  localparam int LIST_DEPTH    = 256;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int KEY_W         = 32;
  localparam int PORT_PAY_W    = 32;
  localparam int FUNC_W        = 2;
  localparam int POLICY_W      = 2;
  localparam int STATUS_W      = 2;
  localparam int ADDR_W        = $clog2(LIST_DEPTH);
  localparam int CNT_W         = $clog2(LIST_DEPTH + 1);
  localparam int ENTRY_W       = KEY_W + PAYLOAD_WIDTH;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_LOOKUP = 2'd2
  } sokl_func_e;

  // Reorder policy after a lookup hit; the unused code keeps the order
  typedef enum logic [POLICY_W-1:0] {
    POL_KEEP      = 2'd0,
    POL_TRANSPOSE = 2'd1,
    POL_TO_FRONT  = 2'd2
  } sokl_policy_e;

  // Result status
  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2
  } sokl_status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_CP_RD,
    S_CP_WR,
    S_FINAL,
    S_DONE
  } sokl_state_e;

  // One result from the sequencer to the output register
  typedef struct packed {
    sokl_status_e            status;
    logic [PORT_PAY_W-1:0]   found_payload;
    logic [CNT_W-1:0]        probes;
    logic [CNT_W-1:0]        list_length;
  } sokl_result_t;

  // Truncate an input payload to the stored width
  function automatic logic [PAYLOAD_WIDTH-1:0] pay_from_port(logic [PORT_PAY_W-1:0] p);
    logic [63:0] w;
    w = 64'(p);
    return w[PAYLOAD_WIDTH-1:0];
  endfunction

  // Zero-extend or truncate a stored payload to the port width
  function automatic logic [PORT_PAY_W-1:0] pay_to_port(logic [PAYLOAD_WIDTH-1:0] p);
    logic [63:0] w;
    w = 64'(p);
    return w[PORT_PAY_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: sv/sokl_ram.sv
`default_nettype none

module sokl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/sokl_ctrl.sv
`default_nettype none

module sokl_ctrl (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire sokl_pkg::sokl_func_e                func_i,
  input  wire logic [sokl_pkg::KEY_W-1:0]          key_i,
  input  wire logic [sokl_pkg::PAYLOAD_WIDTH-1:0]  pay_i,
  input  wire logic [sokl_pkg::POLICY_W-1:0]       policy_i,
  output logic                                     busy_o,
  output logic                                     res_valid_o,
  output sokl_pkg::sokl_result_t                   res_o,
  input  wire logic                                res_take_i,
  output logic                                     ram_we_o,
  output logic [sokl_pkg::ADDR_W-1:0]              ram_waddr_o,
  output logic [sokl_pkg::ENTRY_W-1:0]             ram_wdata_o,
  output logic                                     ram_re_o,
  output logic [sokl_pkg::ADDR_W-1:0]              ram_raddr_o,
  input  wire logic [sokl_pkg::ENTRY_W-1:0]        ram_rdata_i
);

  import sokl_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LIST_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  // Control state
  sokl_state_e              state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     cmp_vld_q, cmp_vld_d;

  // Working registers
  sokl_func_e               func_q, func_d;
  logic [KEY_W-1:0]         key_q, key_d;
  logic [CNT_W-1:0]         idx_q, idx_d;
  logic [CNT_W-1:0]         cmp_idx_q, cmp_idx_d;
  logic [CNT_W-1:0]         j_q, j_d;
  logic [CNT_W-1:0]         stop_q, stop_d;
  logic                     dir_up_q, dir_up_d;
  logic                     fin_en_q, fin_en_d;
  logic [ADDR_W-1:0]        fin_addr_q, fin_addr_d;
  logic [KEY_W-1:0]         fin_key_q, fin_key_d;
  logic [PAYLOAD_WIDTH-1:0] fin_pay_q, fin_pay_d;
  sokl_status_e             status_q, status_d;
  logic [PORT_PAY_W-1:0]    found_q, found_d;
  logic [CNT_W-1:0]         probes_q, probes_d;

  logic [KEY_W-1:0]         rd_key;
  logic [PAYLOAD_WIDTH-1:0] rd_pay;
  logic [CNT_W-1:0]         cmp_nxt;
  logic [CNT_W-1:0]         cmp_prv;
  logic [CNT_W-1:0]         j_nxt;
  logic [CNT_W-1:0]         j_prv;
  logic                     cp_more;

  assign rd_key  = ram_rdata_i[ENTRY_W-1 -: KEY_W];
  assign rd_pay  = ram_rdata_i[PAYLOAD_WIDTH-1:0];
  assign cmp_nxt = cmp_idx_q + ONE_CNT;
  assign cmp_prv = cmp_idx_q - ONE_CNT;
  assign j_nxt   = j_q + ONE_CNT;
  assign j_prv   = j_q - ONE_CNT;
  assign cp_more = dir_up_q ? (j_nxt < count_q) : (j_q != stop_q);

  assign busy_o = (state_q != S_IDLE);

  assign res_o.status        = status_q;
  assign res_o.found_payload = found_q;
  assign res_o.probes        = probes_q;
  assign res_o.list_length   = count_q;

  // Sequencer: walk compares one entry a cycle; copy moves each entry with a read state and then a write state
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cmp_vld_d   = cmp_vld_q;
    func_d      = func_q;
    key_d       = key_q;
    idx_d       = idx_q;
    cmp_idx_d   = cmp_idx_q;
    j_d         = j_q;
    stop_d      = stop_q;
    dir_up_d    = dir_up_q;
    fin_en_d    = fin_en_q;
    fin_addr_d  = fin_addr_q;
    fin_key_d   = fin_key_q;
    fin_pay_d   = fin_pay_q;
    status_d    = status_q;
    found_d     = found_q;
    probes_d    = probes_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          func_d   = func_i;
          key_d    = key_i;
          found_d  = '0;
          probes_d = '0;
          case (func_i)
            FN_INSERT: begin
              if (count_q == FULL_CNT) begin
                status_d = STS_FULL;
                state_d  = S_DONE;
              end else begin
                status_d   = STS_OK;
                count_d    = count_q + ONE_CNT;
                j_d        = count_q;
                stop_d     = '0;
                dir_up_d   = 1'b0;
                fin_en_d   = 1'b1;
                fin_addr_d = '0;
                fin_key_d  = key_i;
                fin_pay_d  = pay_i;
                state_d    = S_CP_RD;
              end
            end
            FN_REMOVE, FN_LOOKUP: begin
              if (count_q == '0) begin
                status_d = STS_NOT_FOUND;
                state_d  = S_DONE;
              end else begin
                idx_d     = '0;
                cmp_vld_d = 1'b0;
                state_d   = S_WALK;
              end
            end
            default: begin
              status_d = STS_NOT_FOUND;
              state_d  = S_DONE;
            end
          endcase
        end
      end

      S_WALK: begin
        // Issue the next read while comparing the previous one
        cmp_idx_d = idx_q;
        if (idx_q < count_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = idx_q[ADDR_W-1:0];
          idx_d       = idx_q + ONE_CNT;
          cmp_vld_d   = 1'b1;
        end else begin
          cmp_vld_d = 1'b0;
        end
        if (cmp_vld_q) begin
          if (rd_key == key_q) begin
            status_d  = STS_OK;
            found_d   = pay_to_port(rd_pay);
            probes_d  = cmp_nxt;
            fin_key_d = rd_key;
            fin_pay_d = rd_pay;
            j_d       = cmp_idx_q;
            if (func_q == FN_REMOVE) begin
              dir_up_d = 1'b1;
              fin_en_d = 1'b0;
              state_d  = S_CP_RD;
            end else if (cmp_idx_q != '0 && policy_i == POL_TRANSPOSE) begin
              dir_up_d   = 1'b0;
              stop_d     = cmp_prv;
              fin_en_d   = 1'b1;
              fin_addr_d = cmp_prv[ADDR_W-1:0];
              state_d    = S_CP_RD;
            end else if (cmp_idx_q != '0 && policy_i == POL_TO_FRONT) begin
              dir_up_d   = 1'b0;
              stop_d     = '0;
              fin_en_d   = 1'b1;
              fin_addr_d = '0;
              state_d    = S_CP_RD;
            end else begin
              state_d = S_DONE;
            end
          end else if (cmp_nxt == count_q) begin
            status_d = STS_NOT_FOUND;
            probes_d = count_q;
            state_d  = S_DONE;
          end
        end
      end

      S_CP_RD: begin
        if (cp_more) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = dir_up_q ? j_nxt[ADDR_W-1:0] : j_prv[ADDR_W-1:0];
          state_d     = S_CP_WR;
        end else begin
          if (func_q == FN_REMOVE) begin
            count_d = count_q - ONE_CNT;
          end
          state_d = fin_en_q ? S_FINAL : S_DONE;
        end
      end

      S_CP_WR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = j_q[ADDR_W-1:0];
        ram_wdata_o = ram_rdata_i;
        j_d         = dir_up_q ? j_nxt : j_prv;
        state_d     = S_CP_RD;
      end

      S_FINAL: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = fin_addr_q;
        ram_wdata_o = {fin_key_q, fin_pay_q};
        state_d     = S_DONE;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    key_q      <= key_d;
    idx_q      <= idx_d;
    cmp_idx_q  <= cmp_idx_d;
    j_q        <= j_d;
    stop_q     <= stop_d;
    dir_up_q   <= dir_up_d;
    fin_en_q   <= fin_en_d;
    fin_addr_q <= fin_addr_d;
    fin_key_q  <= fin_key_d;
    fin_pay_q  <= fin_pay_d;
    status_q   <= status_d;
    found_q    <= found_d;
    probes_q   <= probes_d;
  end

endmodule

`default_nettype wire

// File: sv/self_organizing_key_list.sv
// Insert shifts every listed entry back by one place and writes the new entry at the front.
// Remove and lookup walk one entry a cycle from the front; then a remove, transpose or move
// to front copies each shifted entry, with a read and then a write, through the one RAM port
// pair. The longest item is a move to front of the last of 256 entries.
// One item is in work at a time; the result then sits in an output register, so the next
// item may start while it waits. Reset empties the list and sets the policy to keep order.
`default_nettype none

module self_organizing_key_list (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic [sokl_pkg::FUNC_W-1:0]           func_i,
  input  wire logic signed [sokl_pkg::KEY_W-1:0]     key_i,
  input  wire logic [sokl_pkg::PORT_PAY_W-1:0]       payload_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic [sokl_pkg::STATUS_W-1:0]              status_o,
  output logic [sokl_pkg::PORT_PAY_W-1:0]            found_payload_o,
  output logic [sokl_pkg::CNT_W-1:0]                 probes_o,
  output logic [sokl_pkg::CNT_W-1:0]                 list_length_o,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [sokl_pkg::POLICY_W-1:0]         cfg_data_i
);

  import sokl_pkg::*;

  logic                     busy;
  logic                     start;
  logic                     res_valid;
  logic                     res_take;
  sokl_result_t             res;
  logic [POLICY_W-1:0]      policy_q;
  logic                     out_vld_q, out_vld_d;
  sokl_result_t             out_q;
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [ENTRY_W-1:0]       ram_wdata;
  logic                     ram_re;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]       ram_rdata;

  // Input transfer
  assign in_stall_o = busy;
  assign start      = in_valid_i && !busy;

  // Policy register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_KEEP;
    end else if (cfg_valid_i) begin
      policy_q <= cfg_data_i;
    end
  end

  // Output register: load when empty or being drained
  assign res_take  = !out_vld_q || !out_stall_i;
  assign out_vld_d = (res_valid && res_take) || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = out_q.status;
  assign found_payload_o = out_q.found_payload;
  assign probes_o        = out_q.probes;
  assign list_length_o   = out_q.list_length;

  sokl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .func_i      (sokl_func_e'(func_i)),
    .key_i       (key_i),
    .pay_i       (pay_from_port(payload_i)),
    .policy_i    (policy_q),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  sokl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LIST_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

// File: sim/tb_self_organizing_key_list.sv
`timescale 1ns / 100ps

module tb_self_organizing_key_list;
  import sokl_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [FUNC_W-1:0]   FN_UNUSED  = 2'd3;
  localparam logic [POLICY_W-1:0] POL_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 800;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 40;
  localparam int KEY_POOL_N    = 12;
  localparam int DIR_N         = 24;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [FUNC_W-1:0]       func_i;
  logic signed [KEY_W-1:0] key_i;
  logic [PORT_PAY_W-1:0]   payload_i;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [STATUS_W-1:0]     status_o;
  logic [PORT_PAY_W-1:0]   found_payload_o;
  logic [CNT_W-1:0]        probes_o;
  logic [CNT_W-1:0]        list_length_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [POLICY_W-1:0]     cfg_data_i;

  self_organizing_key_list u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .key_i           (key_i),
    .payload_i       (payload_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .found_payload_o (found_payload_o),
    .probes_o        (probes_o),
    .list_length_o   (list_length_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the list, front at index 0
  logic [KEY_W-1:0]      shadow_keys [LIST_DEPTH];
  logic [PORT_PAY_W-1:0] shadow_pays [LIST_DEPTH];
  int                    shadow_len;
  logic [POLICY_W-1:0]   shadow_policy;

  sokl_result_t          awaited_results [$];
  logic [KEY_W-1:0]      key_pool [KEY_POOL_N];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int ops_sent;
  int results_seen;
  int longest_list;
  int full_rejects;
  int key_hits;
  int cycles;
  int hold_left;
  bit hold_done;

  // Directed rows; typed rows carry their expected result
  typedef struct packed {
    logic [FUNC_W-1:0]     func;
    logic [KEY_W-1:0]      key;
    logic [PORT_PAY_W-1:0] pay;
    logic [POLICY_W-1:0]   policy;
    bit                    typed;
    logic [STATUS_W-1:0]   st;
    logic [PORT_PAY_W-1:0] found;
    logic [CNT_W-1:0]      probes;
    logic [CNT_W-1:0]      len;
  } dir_row_t;

  dir_row_t dir_rows [DIR_N] = '{
    // empty list: misses and the unused operation
    '{FN_LOOKUP, 32'h0000_0000, 32'h0000_0000, POL_KEEP, 1'b1, STS_NOT_FOUND, 32'h0, 9'd0, 9'd0},
    '{FN_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000, POL_KEEP, 1'b1, STS_NOT_FOUND, 32'h0, 9'd0, 9'd0},
    '{FN_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, POL_KEEP, 1'b1, STS_NOT_FOUND, 32'h0, 9'd0, 9'd0},
    // build [0, -1, max, min]
    '{FN_INSERT, 32'h8000_0000, 32'h0000_0000, POL_KEEP, 1'b1, STS_OK, 32'h0, 9'd0, 9'd1},
    '{FN_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, POL_KEEP, 1'b1, STS_OK, 32'h0, 9'd0, 9'd2},
    '{FN_INSERT, 32'hFFFF_FFFF, 32'h1234_5678, POL_KEEP, 1'b1, STS_OK, 32'h0, 9'd0, 9'd3},
    '{FN_INSERT, 32'h0000_0000, 32'hA5A5_A5A5, POL_KEEP, 1'b1, STS_OK, 32'h0, 9'd0, 9'd4},
    // hit at front, hit at back, miss
    '{FN_LOOKUP, 32'h0000_0000, 32'h0, POL_KEEP, 1'b1, STS_OK, 32'hA5A5_A5A5, 9'd1, 9'd4},
    '{FN_LOOKUP, 32'h8000_0000, 32'h0, POL_KEEP, 1'b1, STS_OK, 32'h0, 9'd4, 9'd4},
    '{FN_LOOKUP, 32'h5A5A_5A5A, 32'h0, POL_KEEP, 1'b1, STS_NOT_FOUND, 32'h0, 9'd4, 9'd4},
    // every reorder policy
    '{FN_LOOKUP, 32'h8000_0000, 32'h0, POL_TRANSPOSE, 1'b0, 2'd0, 32'h0, 9'd0, 9'd0},
    '{FN_LOOKUP, 32'h8000_0000, 32'h0, POL_TRANSPOSE, 1'b0, 2'd0, 32'h0, 9'd0, 9'd0},
    '{FN_LOOKUP, 32'h0000_0000, 32'h0, POL_TRANSPOSE, 1'b0, 2'd0, 32'h0, 9'd0, 9'd0},
    '{FN_LOOKUP, 32'h7FFF_FFFF, 32'h0, POL_TO_FRONT, 1'b0, 2'd0, 32'h0, 9'd0, 9'd0},
    '{FN_LOOKUP, 32'hFFFF_FFFF, 32'h0, POL_TO_FRONT, 1'b0, 2'd0, 32'h0, 9'd0, 9'd0},
    '{FN_LOOKUP, 32'h8000_0000, 32'h0, POL_UNUSED, 1'b0, 2'd0, 32'h0, 9'd0, 9'd0},
    '{FN_UNUSED, 32'h0000_0000, 32'h0, POL_UNUSED, 1'b1, STS_NOT_FOUND, 32'h0, 9'd0, 9'd4},
    // duplicate key, then removes at front, middle, back and a miss
    '{FN_INSERT, 32'h0000_0000, 32'h0000_0001, POL_UNUSED, 1'b1, STS_OK, 32'h0, 9'd0, 9'd5},
    '{FN_REMOVE, 32'h0000_0000, 32'h0, POL_UNUSED, 1'b0, 2'd0, 32'h0, 9'd0, 9'd0},
    '{FN_REMOVE, 32'h0000_0000, 32'h0, POL_UNUSED, 1'b0, 2'd0, 32'h0, 9'd0, 9'd0},
    '{FN_REMOVE, 32'h8000_0000, 32'h0, POL_UNUSED, 1'b0, 2'd0, 32'h0, 9'd0, 9'd0},
    '{FN_REMOVE, 32'h0000_1234, 32'h0, POL_UNUSED, 1'b0, 2'd0, 32'h0, 9'd0, 9'd0},
    '{FN_REMOVE, 32'hFFFF_FFFF, 32'h0, POL_UNUSED, 1'b0, 2'd0, 32'h0, 9'd0, 9'd0},
    '{FN_REMOVE, 32'h7FFF_FFFF, 32'h0, POL_UNUSED, 1'b0, 2'd0, 32'h0, 9'd0, 9'd0}
  };

  // Apply one operation to the shadow list and return the result it gives
  function automatic sokl_result_t apply_list_op(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                                                 logic [PORT_PAY_W-1:0] p);
    sokl_result_t          r;
    int                    hit;
    logic [KEY_W-1:0]      hk;
    logic [PORT_PAY_W-1:0] hp;
    r = '0;
    r.status = STS_NOT_FOUND;
    if (f == FN_INSERT) begin
      if (shadow_len >= LIST_DEPTH) begin
        r.status = STS_FULL;
        full_rejects++;
      end else begin
        for (int j = shadow_len; j > 0; j--) begin
          shadow_keys[j] = shadow_keys[j-1];
          shadow_pays[j] = shadow_pays[j-1];
        end
        shadow_keys[0] = k;
        shadow_pays[0] = p;
        shadow_len++;
        r.status = STS_OK;
      end
    end else if (f == FN_REMOVE || f == FN_LOOKUP) begin
      // first match from the front
      hit = shadow_len;
      for (int i = 0; i < shadow_len; i++) begin
        if (hit == shadow_len && shadow_keys[i] == k) hit = i;
      end
      r.probes = (hit < shadow_len) ? CNT_W'(hit + 1) : CNT_W'(shadow_len);
      if (hit < shadow_len) begin
        key_hits++;
        hk = shadow_keys[hit];
        hp = shadow_pays[hit];
        r.status = STS_OK;
        r.found_payload = hp;
        if (f == FN_REMOVE) begin
          for (int j = hit; j + 1 < shadow_len; j++) begin
            shadow_keys[j] = shadow_keys[j+1];
            shadow_pays[j] = shadow_pays[j+1];
          end
          shadow_len--;
        end else if (hit > 0 && shadow_policy == POL_TRANSPOSE) begin
          shadow_keys[hit]   = shadow_keys[hit-1];
          shadow_pays[hit]   = shadow_pays[hit-1];
          shadow_keys[hit-1] = hk;
          shadow_pays[hit-1] = hp;
        end else if (hit > 0 && shadow_policy == POL_TO_FRONT) begin
          for (int j = hit; j > 0; j--) begin
            shadow_keys[j] = shadow_keys[j-1];
            shadow_pays[j] = shadow_pays[j-1];
          end
          shadow_keys[0] = hk;
          shadow_pays[0] = hp;
        end
      end
    end
    r.list_length = CNT_W'(shadow_len);
    if (shadow_len > longest_list) longest_list = shadow_len;
    return r;
  endfunction

  // Mostly keys from a small pool so that duplicates and hits occur
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(3) == 0) return $urandom();
    return key_pool[$urandom_range(KEY_POOL_N - 1)];
  endfunction

  // Offer one item, hold it until the transfer, then record its expected result
  task automatic send_op(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                         input logic [PORT_PAY_W-1:0] p, input bit use_typed = 1'b0,
                         input sokl_result_t typed_res = '0);
    sokl_result_t r;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    key_i      <= k;
    payload_i  <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = apply_list_op(f, k, p);
    awaited_results.push_back(use_typed ? typed_res : r);
    ops_sent++;
  endtask

  // Drain the block, then write the policy register
  task automatic write_policy(input logic [POLICY_W-1:0] pol);
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= pol;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i   <= 1'b0;
    shadow_policy = pol;
  endtask

  // Random mix on a short list; removes and lookups mostly hit
  task automatic random_op();
    int                  r;
    int                  ins_w;
    logic [FUNC_W-1:0]   f;
    logic [KEY_W-1:0]    k;
    r     = $urandom_range(99);
    ins_w = (shadow_len < 12) ? 45 : 20;
    if (r < 3)                  f = FN_UNUSED;
    else if (r < 3 + ins_w)     f = FN_INSERT;
    else if (r < 28 + ins_w)    f = FN_REMOVE;
    else                        f = FN_LOOKUP;
    if (f != FN_INSERT && shadow_len > 0 && $urandom_range(99) < 80)
      k = shadow_keys[$urandom_range(shadow_len - 1)];
    else
      k = pick_key();
    send_op(f, k, $urandom());
  endtask

  // Run guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               awaited_results.size());
      $display("tb_self_organizing_key_list: FAIL");
      $finish;
    end
  end

  // Result side: check each transfer, then pick the next stall
  always @(posedge clk_i) begin : rx_side
    sokl_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        $error("result with nothing expected: status %0d payload %h", status_o,
               found_payload_o);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
        if (found_payload_o !== want.found_payload) begin
          $error("found_payload: expected %h, got %h", want.found_payload, found_payload_o);
          mismatches++;
        end
        if (probes_o !== want.probes) begin
          $error("probes: expected %0d, got %0d", want.probes, probes_o);
          mismatches++;
        end
        if (list_length_o !== want.list_length) begin
          $error("list_length: expected %0d, got %0d", want.list_length, list_length_o);
          mismatches++;
        end
      end
    end
    // one long hold-off so the block backs up into its input
    if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    sokl_result_t typed_res;
    logic [KEY_W-1:0] k;
    int idx;
    in_valid_i    = 1'b0;
    func_i        = FN_INSERT;
    key_i         = '0;
    payload_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = POL_KEEP;
    rst_ni        = 1'b0;
    shadow_len    = 0;
    shadow_policy = POL_KEEP;
    send_idle_pct = 27;
    recv_idle_pct = 69;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < KEY_POOL_N; i++) key_pool[i] = $urandom();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_policy(POL_KEEP);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].policy != shadow_policy) write_policy(dir_rows[i].policy);
      typed_res.status        = sokl_status_e'(dir_rows[i].st);
      typed_res.found_payload = dir_rows[i].found;
      typed_res.probes        = dir_rows[i].probes;
      typed_res.list_length   = dir_rows[i].len;
      send_op(dir_rows[i].func, dir_rows[i].key, dir_rows[i].pay, dir_rows[i].typed,
              typed_res);
    end

    // short lists, sender idles less than receiver
    write_policy(POL_TRANSPOSE);
    repeat (130) random_op();

    // short lists, roles swapped
    send_idle_pct = 69;
    recv_idle_pct = 27;
    write_policy(POL_TO_FRONT);
    repeat (130) random_op();

    // fill to capacity at full rate, then push against the full list
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_policy(POL_UNUSED);
    while (shadow_len < LIST_DEPTH) send_op(FN_INSERT, pick_key(), $urandom());
    repeat (4) send_op(FN_INSERT, pick_key(), $urandom());

    // deep hits and misses near the back of a long list
    for (int p = 0; p < 2; p++) begin
      write_policy(p == 0 ? POL_TO_FRONT : POL_KEEP);
      send_op(FN_LOOKUP, $urandom(), $urandom());
      repeat (9) begin
        idx = shadow_len - 1 - $urandom_range(3);
        k   = shadow_keys[idx];
        send_op($urandom_range(1) ? FN_LOOKUP : FN_REMOVE, k, $urandom());
      end
    end
    while (shadow_len < LIST_DEPTH) send_op(FN_INSERT, pick_key(), $urandom());
    send_op(FN_INSERT, pick_key(), $urandom());

    // wait out every result, then allow for a stray one
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d operations (%0d key hits, %0d rejected on a full list), list length up to %0d,",
             ops_sent, key_hits, full_rejects, longest_list);
    $display("under all four policy codes, with sender and receiver stalls and one long hold-off.");
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("tb_self_organizing_key_list: PASS");
    end else begin
      $display("tb_self_organizing_key_list: FAIL");
    end
    $finish;
  end

endmodule

// File: self_organizing_key_list.f
sv/sokl_pkg.sv
sv/sokl_ram.sv
sv/sokl_ctrl.sv
sv/self_organizing_key_list.sv
sim/tb_self_organizing_key_list.sv
